FILE: rtl/ptb_pkg.sv
// Shared constants for the palindromic tree builder: defaults, field widths and root codes.
`default_nettype none

package ptb_pkg;

  // Default capacity in letters and default alphabet size.
  localparam int unsigned MAX_LEN_DEF  = 1024;
  localparam int unsigned ALPHABET_DEF = 26;

  // Fixed field widths of the request and result channels.
  localparam int unsigned LETTER_W  = 5;
  localparam int unsigned S_TDATA_W = 8;
  localparam int unsigned S_TUSER_W = 1;
  localparam int unsigned M_TUSER_W = 2;

  // Bit positions of the flags in the result tuser.
  localparam int unsigned TUSER_IS_NEW   = 0;
  localparam int unsigned TUSER_OVERFLOW = 1;

  // Node codes: the imaginary root of length -1, the empty root, the first real node.
  localparam int unsigned ROOT_NEG   = 1;
  localparam int unsigned ROOT_EMPTY = 2;
  localparam int unsigned FIRST_NODE = 3;

endpackage

`default_nettype wire

FILE: rtl/palindromic_tree_builder_core.sv
// Top level of the palindromic tree (eertree) builder: sequencer, registers and memories.
//
//  Channel | Direction | tdata (low bit up)                                   | tuser (low bit up)
//  s_*     | in        | letter[4:0], zero fill to 8 bits                     | new_string
//  m_*     | out       | suffix_node, suffix_length, pal_start, distinct_count | is_new, overflow
//
// One request at a time: the walk ends at once on the imaginary root, or reads each further node it
// visits and, when that node needs it, does the letter compare.
// A new node longer than one letter adds a second walk and a link read.
// After reset all NODE_CAP * ALPHABET edge table entries (26702 by default) are cleared with
// s_tready low; stale edges after a new string are rejected by checking the parent of the target.
// s_tready is high only while the sequencer is idle; a held result only delays the next load.
`default_nettype none

module palindromic_tree_builder_core
  import ptb_pkg::*;
#(
  parameter int unsigned MAX_LEN  = MAX_LEN_DEF,
  parameter int unsigned ALPHABET = ALPHABET_DEF,
  localparam int unsigned NODE_CAP  = MAX_LEN + 3,
  localparam int unsigned NODE_W    = $clog2(NODE_CAP),
  localparam int unsigned LEN_W     = $clog2(MAX_LEN + 1),
  localparam int unsigned POS_W     = $clog2(MAX_LEN),
  localparam int unsigned OUT_W     = NODE_W + 2 * LEN_W + POS_W,
  localparam int unsigned M_TDATA_W = ((OUT_W + 7) / 8) * 8
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  input  wire logic [S_TDATA_W-1:0] s_tdata,   // letter, zero fill
  input  wire logic [S_TUSER_W-1:0] s_tuser,   // new_string
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  output logic [M_TDATA_W-1:0]      m_tdata,   // suffix_node, suffix_length, pal_start,
                                               // distinct_count, zero fill
  output logic [M_TUSER_W-1:0]      m_tuser    // is_new, overflow
);

  localparam int unsigned EDGE_DEPTH = NODE_CAP * ALPHABET;
  localparam int unsigned EDGE_AW    = $clog2(EDGE_DEPTH);

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_WREAD = 11'b000_0000_0010,
    ST_WLEN  = 11'b000_0000_0100,
    ST_WCMP  = 11'b000_0000_1000,
    ST_EMUL  = 11'b000_0001_0000,
    ST_EREAD = 11'b000_0010_0000,
    ST_ECHK  = 11'b000_0100_0000,
    ST_EVAL  = 11'b000_1000_0000,
    ST_LINK  = 11'b001_0000_0000,
    ST_OUT   = 11'b010_0000_0000,
    ST_CLEAR = 11'b100_0000_0000
  } state_t;

  // One node record; all fields are written together when the node is complete.
  typedef struct packed {
    logic [LEN_W-1:0]    len;
    logic [NODE_W-1:0]   link;
    logic [POS_W-1:0]    end_pos;
    logic [NODE_W-1:0]   par_node;
    logic [LETTER_W-1:0] par_char;
  } node_rec_t;

  localparam int unsigned NREC_W = $bits(node_rec_t);

  state_t              state;
  logic [LEN_W-1:0]    position;
  logic [POS_W-1:0]    idx;
  logic [LETTER_W-1:0] chr;
  logic [NODE_W-1:0]   cur_node;
  logic [LEN_W-1:0]    cur_len;
  logic [POS_W-1:0]    cur_start;
  logic [NODE_W-1:0]   last_node;
  logic [NODE_W-1:0]   walk_node;
  logic [NODE_W-1:0]   walk_link;
  logic [LEN_W-1:0]    walk_len;
  logic                second;
  logic [NODE_W-1:0]   x_node;
  logic [NODE_W-1:0]   x_link;
  logic [LEN_W-1:0]    x_len;
  logic [NODE_W-1:0]   e_node;
  logic [EDGE_AW-1:0]  edge_addr;
  logic [EDGE_AW-1:0]  clr_addr;
  logic                ovf_flag;
  logic                new_flag;

  // Memory ports.
  logic                letter_we;
  logic [POS_W-1:0]    letter_waddr;
  logic [POS_W-1:0]    letter_raddr;
  logic [LETTER_W-1:0] letter_rdata;
  logic                node_we;
  logic [NODE_W-1:0]   node_waddr;
  node_rec_t           node_wrec;
  logic [NODE_W-1:0]   node_raddr;
  node_rec_t           node_rrec;
  logic                edge_we;
  logic [EDGE_AW-1:0]  edge_waddr;
  logic [NODE_W-1:0]   edge_wdata;
  logic [NODE_W-1:0]   edge_rdata;

  // Combinational helpers.
  logic                s_fire;
  logic                new_string;
  logic [LETTER_W-1:0] c_sat;
  logic [LEN_W-1:0]    pos_eff;
  logic                pos_full;
  logic                w_root_neg;
  logic                w_root_empty;
  logic [LEN_W-1:0]    w_len;
  logic [NODE_W-1:0]   w_link;
  logic [POS_W-1:0]    mirror_pos;
  logic                edge_ok;
  logic [NODE_W-1:0]   nn_idx;
  logic                x_root;
  logic [LEN_W-1:0]    nn_len;
  logic                out_free;

  function automatic logic [POS_W-1:0] start_of(input logic [POS_W-1:0] end_pos,
                                                 input logic [LEN_W-1:0] len);
    logic [LEN_W:0] t;
    t = (LEN_W+1)'(end_pos) + (LEN_W+1)'(1) - (LEN_W+1)'(len);
    return t[POS_W-1:0];
  endfunction

  // Request decode: saturate the letter and apply a pending clear to the position.
  assign s_tready   = (state == ST_IDLE);
  assign s_fire     = s_tvalid && s_tready;
  assign new_string = s_tuser[0];
  assign c_sat      = (32'(s_tdata[LETTER_W-1:0]) >= ALPHABET) ? LETTER_W'(ALPHABET - 1)
                                                                : s_tdata[LETTER_W-1:0];
  assign pos_eff    = new_string ? '0 : position;
  assign pos_full   = (pos_eff >= LEN_W'(MAX_LEN));

  // Walk step: roots have fixed records, other nodes come from the node memory.
  assign w_root_neg   = (walk_node == NODE_W'(ROOT_NEG));
  assign w_root_empty = (walk_node == NODE_W'(ROOT_EMPTY));
  assign w_len        = (w_root_neg || w_root_empty) ? '0 : node_rrec.len;
  assign w_link       = (w_root_neg || w_root_empty) ? NODE_W'(ROOT_NEG) : node_rrec.link;
  assign mirror_pos   = POS_W'(LEN_W'(idx) - w_len - LEN_W'(1));

  // An edge is real only if its target is a live node whose recorded parent matches.
  assign edge_ok = (e_node >= NODE_W'(FIRST_NODE)) && (e_node <= last_node) &&
                   (node_rrec.par_node == x_node) && (node_rrec.par_char == chr);
  assign nn_idx  = last_node + NODE_W'(1);
  assign x_root  = (x_node == NODE_W'(ROOT_NEG));
  assign nn_len  = x_root ? LEN_W'(1) : x_len + LEN_W'(2);
  assign out_free = !m_tvalid || m_tready;

  // Memory address and write control follow the sequencer state.
  always_comb begin
    letter_we    = s_fire && !pos_full;
    letter_waddr = pos_eff[POS_W-1:0];
    letter_raddr = mirror_pos;
    node_raddr   = (state == ST_ECHK) ? edge_rdata : walk_node;
    node_we      = 1'b0;
    node_waddr   = cur_node;
    node_wrec    = '{len: cur_len, link: edge_rdata, end_pos: idx,
                     par_node: x_node, par_char: chr};
    edge_we      = 1'b0;
    edge_waddr   = edge_addr;
    edge_wdata   = nn_idx;
    case (state)
      ST_CLEAR: begin
        edge_we    = 1'b1;
        edge_waddr = clr_addr;
        edge_wdata = '0;
      end
      ST_EVAL: begin
        edge_we = !edge_ok;
        if (!edge_ok && x_root) begin
          node_we    = 1'b1;
          node_waddr = nn_idx;
          node_wrec  = '{len: nn_len, link: NODE_W'(ROOT_EMPTY), end_pos: idx,
                         par_node: x_node, par_char: chr};
        end
      end
      ST_LINK: begin
        node_we = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Sequencer and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      clr_addr  <= '0;
      position  <= '0;
      cur_node  <= NODE_W'(ROOT_NEG);
      cur_len   <= '0;
      cur_start <= '0;
      last_node <= NODE_W'(ROOT_EMPTY);
      m_tvalid  <= 1'b0;
      second    <= 1'b0;
      ovf_flag  <= 1'b0;
      new_flag  <= 1'b0;
    end else begin
      if (state == ST_OUT && out_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_CLEAR: begin
          clr_addr <= clr_addr + EDGE_AW'(1);
          if (clr_addr == EDGE_AW'(EDGE_DEPTH - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            chr      <= c_sat;
            new_flag <= 1'b0;
            second   <= 1'b0;
            if (new_string) begin
              last_node <= NODE_W'(ROOT_EMPTY);
              cur_node  <= NODE_W'(ROOT_NEG);
              cur_len   <= '0;
              cur_start <= '0;
            end
            if (pos_full) begin
              ovf_flag <= 1'b1;
              state    <= ST_OUT;
            end else begin
              ovf_flag  <= 1'b0;
              idx       <= pos_eff[POS_W-1:0];
              position  <= pos_eff + LEN_W'(1);
              walk_node <= new_string ? NODE_W'(ROOT_NEG) : cur_node;
              state     <= ST_WREAD;
            end
          end
        end
        ST_WREAD: begin
          state <= ST_WLEN;
        end
        ST_WLEN: begin
          walk_link <= w_link;
          walk_len  <= w_len;
          if (w_root_neg) begin
            state <= ST_EMUL;
          end else if (w_len >= LEN_W'(idx)) begin
            walk_node <= w_link;
            state     <= ST_WREAD;
          end else begin
            state <= ST_WCMP;
          end
        end
        ST_WCMP: begin
          if (letter_rdata == chr) begin
            state <= ST_EMUL;
          end else begin
            walk_node <= walk_link;
            state     <= ST_WREAD;
          end
        end
        ST_EMUL: begin
          edge_addr <= EDGE_AW'(EDGE_AW'(walk_node) * EDGE_AW'(ALPHABET)) + EDGE_AW'(chr);
          if (!second) begin
            x_node <= walk_node;
            x_link <= walk_link;
            x_len  <= walk_len;
          end
          state <= ST_EREAD;
        end
        ST_EREAD: begin
          state <= second ? ST_LINK : ST_ECHK;
        end
        ST_ECHK: begin
          e_node <= edge_rdata;
          state  <= ST_EVAL;
        end
        ST_EVAL: begin
          if (edge_ok) begin
            cur_node  <= e_node;
            cur_len   <= node_rrec.len;
            cur_start <= start_of(node_rrec.end_pos, node_rrec.len);
            state     <= ST_OUT;
          end else begin
            last_node <= nn_idx;
            cur_node  <= nn_idx;
            cur_len   <= nn_len;
            cur_start <= start_of(idx, nn_len);
            new_flag  <= 1'b1;
            if (x_root) begin
              state <= ST_OUT;
            end else begin
              second    <= 1'b1;
              walk_node <= x_link;
              state     <= ST_WREAD;
            end
          end
        end
        ST_LINK: begin
          state <= ST_OUT;
        end
        ST_OUT: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Result register, loaded when the result slot is free.
  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      m_tdata <= M_TDATA_W'({LEN_W'(last_node - NODE_W'(ROOT_EMPTY)), cur_start,
                             cur_len, cur_node});
      m_tuser[TUSER_IS_NEW]   <= new_flag;
      m_tuser[TUSER_OVERFLOW] <= ovf_flag;
    end
  end

  // Stored letters by position; the letter is written in the accepting cycle unless the store is full.
  ptb_ram #(
    .WIDTH (LETTER_W),
    .DEPTH (MAX_LEN)
  ) u_letter_ram (
    .clk   (clk),
    .we    (letter_we),
    .waddr (letter_waddr),
    .wdata (c_sat),
    .raddr (letter_raddr),
    .rdata (letter_rdata)
  );

  // Node records: length, suffix link, end position and parent edge.
  ptb_ram #(
    .WIDTH (NREC_W),
    .DEPTH (NODE_CAP)
  ) u_node_ram (
    .clk   (clk),
    .we    (node_we),
    .waddr (node_waddr),
    .wdata (node_wrec),
    .raddr (node_raddr),
    .rdata (node_rrec)
  );

  // Edge table indexed by node and letter.
  ptb_ram #(
    .WIDTH (NODE_W),
    .DEPTH (EDGE_DEPTH)
  ) u_edge_ram (
    .clk   (clk),
    .we    (edge_we),
    .waddr (edge_waddr),
    .wdata (edge_wdata),
    .raddr (edge_addr),
    .rdata (edge_rdata)
  );

  // At most one node per stored letter beyond the two roots.
  a_node_count: assert property (@(posedge clk) disable iff (rst)
    (LEN_W + 1)'(last_node) <= (LEN_W + 1)'(position) + (LEN_W + 1)'(ROOT_EMPTY))
    else $error("node count exceeds letters stored");

  // The current suffix node is always a live node.
  a_cur_live: assert property (@(posedge clk) disable iff (rst)
    cur_node <= last_node && cur_node >= NODE_W'(ROOT_NEG))
    else $error("current node outside the tree");

  // A missing edge creates exactly one node.
  a_node_inc: assert property (@(posedge clk) disable iff (rst)
    (state == ST_EVAL && !edge_ok) |=> last_node == $past(last_node) + NODE_W'(1))
    else $error("node creation did not advance the node count");

  // A held result is not overwritten by the next one.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("held result overwritten");

endmodule

`default_nettype wire

FILE: rtl/ptb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none

module ptb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
